@@ rtl/vtpd_pkg.sv @@
// Package with the beat types and pipeline record types of the vertex transform core.
package vtpd_pkg;

	localparam int NumRegs = 8;
	localparam int CfgIdxW = 3;
	localparam int ColW    = 50;  // floored Q16.16 column sum
	localparam int MagW    = 49;  // magnitude of a column sum
	localparam int QuoW    = 32;  // quotient bits in Q16.16
	localparam int FracW   = 16;

	localparam logic [63:0] RegReset [NumRegs] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

	localparam logic MODE_POINT = 1'b0;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_zero;
		logic               overflow;
	} res_t;

	// One divider lane: partial remainder, quotient so far, unused dividend bits.
	typedef struct packed {
		logic [MagW-1:0]  rem;
		logic [QuoW-1:0]  quo;
		logic [FracW-1:0] alo;
		logic             neg;
		logic             big;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]       lane;
		logic [MagW-1:0]   den;
		logic              point;
		logic              wz;
		logic [2:0][31:0]  dir;
		logic              dovf;
	} div_t;

endpackage

@@ rtl/vertex_transform_perspective_divide_core.sv @@
// Top level of the vertex transform core: 4x4 multiply, floor shift, pipelined divide.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------
//  vertex  | vtx_valid | vtx_stall | vtx (mode, in_x, in_y, in_z)
//  result  | res_valid | res_stall | res (out_x..z, w_zero, overflow)
//  config  | cfg_we    | none      | cfg_index, cfg_data
//
// One beat enters per cycle while the result is not stalled; every beat passes one multiply stage,
// two adder stages, one setup stage, 32 restoring-divide stages (one quotient bit
// each) and the output register. The divider depth sets the latency.
// Reset loads the identity matrix and empties the pipeline.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module vertex_transform_perspective_divide_core
	import vtpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  vtx_t               vtx,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [63:0]        cfg_data
);

	logic [63:0] mat_q [NumRegs];
	logic        en;

	// Matrix element at row r, column c as a signed Q16.16 word.
	function automatic logic signed [31:0] elem(input logic [1:0] r, input logic [1:0] c,
			input logic [63:0] m [NumRegs]);
		logic [63:0] w;
		begin
			w = m[{r, c[1]}];
			elem = c[0] ? w[63:32] : w[31:0];
		end
	endfunction

	// Matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) mat_q[i] <= RegReset[i];
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// The whole pipeline moves unless a finished result is held.
	assign en        = !(res_valid && res_stall);
	assign vtx_stall = !en;

	// Stage 1: the twelve products of the upper three rows, all four columns.
	logic                    valid_s1;
	logic                    mode_s1;
	logic signed [63:0]      prod_s1 [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= vtx_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= vtx.mode;
			for (int c = 0; c < 4; c++) begin
				prod_s1[c][0] <= vtx.in_x * elem(2'd0, 2'(c), mat_q);
				prod_s1[c][1] <= vtx.in_y * elem(2'd1, 2'(c), mat_q);
				prod_s1[c][2] <= vtx.in_z * elem(2'd2, 2'(c), mat_q);
			end
		end
	end

	// Stage 2: pairwise sums, translation added only for points.
	logic               valid_s2;
	logic               mode_s2;
	logic signed [64:0] pa_s2 [4];
	logic signed [64:0] pb_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		logic signed [64:0] tr;
		logic signed [31:0] t3;
		if (en) begin
			mode_s2 <= mode_s1;
			for (int c = 0; c < 4; c++) begin
				t3 = elem(2'd3, 2'(c), mat_q);
				tr = (mode_s1 == MODE_POINT) ? {{17{t3[31]}}, t3, 16'd0} : 65'sd0;
				pa_s2[c] <= 65'(prod_s1[c][0]) + 65'(prod_s1[c][1]);
				pb_s2[c] <= 65'(prod_s1[c][2]) + tr;
			end
		end
	end

	// Stage 3: full column sums, floored to Q16.16.
	logic                  valid_s3;
	logic                  mode_s3;
	logic signed [ColW-1:0] col_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		logic signed [65:0] sum;
		if (en) begin
			mode_s3 <= mode_s2;
			for (int c = 0; c < 4; c++) begin
				sum       = 66'(pa_s2[c]) + 66'(pb_s2[c]);
				col_s3[c] <= sum[65:16];
			end
		end
	end

	// Stage 4: divider setup, zero-w check and direction-mode saturation.
	function automatic logic [MagW-1:0] mag(input logic signed [ColW-1:0] v);
		logic [ColW-1:0] a;
		begin
			a   = v[ColW-1] ? ColW'(-v) : ColW'(v);
			mag = a[MagW-1:0];
		end
	endfunction

	div_t div_s [QuoW+1];
	logic valid_div_s [QuoW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_div_s[0] <= 1'b0;
		else if (en) valid_div_s[0] <= valid_s3;
	end

	always_ff @(posedge clk) begin
		div_t            d;
		logic [MagW-1:0] an;
		logic [MagW-1:0] ad;
		logic signed [ColW-1:0] v;
		if (en) begin
			ad     = mag(col_s3[3]);
			d      = '0;
			d.den  = ad;
			d.point = (mode_s3 == MODE_POINT);
			d.wz   = (mode_s3 == MODE_POINT) && (col_s3[3] == '0);
			for (int c = 0; c < 3; c++) begin
				an              = mag(col_s3[c]);
				d.lane[c].rem   = MagW'(an[MagW-1:FracW]);
				d.lane[c].alo   = an[FracW-1:0];
				d.lane[c].neg   = col_s3[c][ColW-1] ^ col_s3[3][ColW-1];
				d.lane[c].big   = (MagW'(an[MagW-1:FracW]) >= ad);
				v = col_s3[c];
				if (v > ColW'(64'sd2147483647)) begin
					d.dir[c] = 32'h7fff_ffff;
					d.dovf   = 1'b1;
				end else if (v < -ColW'(64'sd2147483648)) begin
					d.dir[c] = 32'h8000_0000;
					d.dovf   = 1'b1;
				end else begin
					d.dir[c] = v[31:0];
				end
			end
			div_s[0] <= d;
		end
	end

	// Divide stages: one restoring step per lane and stage.
	for (genvar k = 0; k < QuoW; k++) begin : g_div
		localparam int Bit = QuoW - 1 - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_div_s[k+1] <= 1'b0;
			else if (en) valid_div_s[k+1] <= valid_div_s[k];
		end

		always_ff @(posedge clk) begin
			div_t          d;
			logic [MagW:0] t;
			logic          b;
			if (en) begin
				d = div_s[k];
				for (int c = 0; c < 3; c++) begin
					b = (Bit >= FracW) ? d.lane[c].alo[Bit % FracW] : 1'b0;
					t = {d.lane[c].rem, b};
					if (t >= {1'b0, d.den}) begin
						t                 = t - {1'b0, d.den};
						d.lane[c].quo     = {d.lane[c].quo[QuoW-2:0], 1'b1};
					end else begin
						d.lane[c].quo     = {d.lane[c].quo[QuoW-2:0], 1'b0};
					end
					d.lane[c].rem = t[MagW-1:0];
				end
				div_s[k+1] <= d;
			end
		end
	end

	// Output register: sign, saturation and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (en) res_valid <= valid_div_s[QuoW];
	end

	always_ff @(posedge clk) begin
		div_t             d;
		logic [2:0][31:0] o;
		logic             ovf;
		logic [QuoW-1:0]  q;
		if (en) begin
			d   = div_s[QuoW];
			o   = '0;
			ovf = 1'b0;
			if (!d.point) begin
				o   = d.dir;
				ovf = d.dovf;
			end else if (!d.wz) begin
				for (int c = 0; c < 3; c++) begin
					q = d.lane[c].quo;
					if (d.lane[c].big) begin
						o[c] = d.lane[c].neg ? 32'h8000_0000 : 32'h7fff_ffff;
						ovf  = 1'b1;
					end else if (!d.lane[c].neg) begin
						if (q[31]) begin
							o[c] = 32'h7fff_ffff;
							ovf  = 1'b1;
						end else begin
							o[c] = q;
						end
					end else begin
						if (q > 32'h8000_0000) begin
							o[c] = 32'h8000_0000;
							ovf  = 1'b1;
						end else begin
							o[c] = 32'(-q);
						end
					end
				end
			end
			res.out_x    <= o[0];
			res.out_y    <= o[1];
			res.out_z    <= o[2];
			res.w_zero   <= d.point && d.wz;
			res.overflow <= ovf;
		end
	end

endmodule
